### hdl/flce_pkg.sv
// shared types, codes and sizes of the fixed-capacity list engine
`default_nettype none
package flce_pkg;

    localparam int unsigned CAP_DEF = 256;
    localparam int unsigned IDX_W   = 13;
    localparam int unsigned WORD_W  = 32;
    localparam int unsigned GROUP_W = 16;

    // command codes
    localparam logic [3:0] CMD_PUSH   = 4'd0;
    localparam logic [3:0] CMD_POP    = 4'd1;
    localparam logic [3:0] CMD_CLEAR  = 4'd2;
    localparam logic [3:0] CMD_ERASE  = 4'd3;
    localparam logic [3:0] CMD_READ   = 4'd4;
    localparam logic [3:0] CMD_WRITE  = 4'd5;
    localparam logic [3:0] CMD_FIND   = 4'd6;
    localparam logic [3:0] CMD_INSERT = 4'd7;
    localparam logic [3:0] CMD_RESIZE = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    // cell update operations
    localparam logic [2:0] OP_HOLD = 3'd0;
    localparam logic [2:0] OP_PUT  = 3'd1;
    localparam logic [2:0] OP_DOWN = 3'd2;
    localparam logic [2:0] OP_UP   = 3'd3;
    localparam logic [2:0] OP_ZERO = 3'd4;

    // cell flag modes
    localparam logic [1:0] FL_NONE  = 2'd0;
    localparam logic [1:0] FL_MATCH = 2'd1;
    localparam logic [1:0] FL_SEL   = 2'd2;

    typedef struct packed {
        logic [2:0]        op;
        logic [1:0]        fmode;
        logic [IDX_W-1:0]  a;
        logic [IDX_W-1:0]  b;
        logic [WORD_W-1:0] word;
    } t_cell_ctl;

    typedef struct packed {
        logic             hit;
        logic             last;
        logic [IDX_W-1:0] index;
    } t_scan_st;

endpackage
`default_nettype wire

### hdl/fixed_capacity_list_engine_core.sv
// top level of the fixed-capacity list engine
// Ordered list of signed 32-bit words held in a row of CAPACITY cells, one entry per cell,
// with a length register. One command is taken at a time. Push, erase, write, insert and
// resize update the cells together in the EXEC state (erase and insert shift the row by
// one through neighbor links); pop and clear only change the length. The result then
// passes through the DONE state into the output register, and the next command is taken
// once it has entered there. Read at a valid position and find scan the cell flags 16
// cells per cycle, first group first, and stop at the group holding the hit (a miss walks
// every group, ceil(CAPACITY/16) but at least 2, 16 at the default 256 entries). A
// finished result waits in the output register while the next command is taken. Entries
// past the length are never visible. The length and found index ports are 9 bits wide.
`default_nettype none
module fixed_capacity_list_engine_core #(
    parameter int unsigned CAPACITY = flce_pkg::CAP_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [3:0]          i_cmd,
    input  wire logic signed [9:0]   i_position,
    input  wire logic signed [31:0]  i_word,
    input  wire logic [8:0]          i_new_length,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic signed [31:0]       o_read_value,
    output logic signed [8:0]        o_found_index,
    output logic [8:0]               o_length,
    output logic [2:0]               o_status
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = flce_pkg::IDX_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0]   r_state, n_state;
    logic [3:0]   r_cmd;
    logic [9:0]   r_pos;
    logic [31:0]  r_word;
    logic [8:0]   r_len_req;
    logic [CW-1:0] r_count, n_count;

    logic [31:0]  r_res_value, n_res_value;
    logic [8:0]   r_res_found, n_res_found;
    logic [2:0]   r_res_status, n_res_status;
    logic         res_load;

    logic         r_out_valid;
    logic [31:0]  r_out_value;
    logic [8:0]   r_out_found;
    logic [8:0]   r_out_length;
    logic [2:0]   r_out_status;

    flce_pkg::t_cell_ctl                  ctl;
    flce_pkg::t_scan_st                   scan_st;
    logic [CAPACITY-1:0]                  flags;
    logic [CAPACITY-1:0][31:0]            entries;
    logic [31:0]                          scan_value;
    logic                                 scan_start, scan_run;

    logic [XW-1:0] cnt_x, cap_x, pos_x, at_x, req_x, req_c;
    logic          pos_neg, pos_ok, full, empty, accept, out_free;

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || !i_rst_n;
    assign out_free   = !r_out_valid || !i_out_stall;

    assign cnt_x   = XW'(r_count);
    assign cap_x   = XW'(CAPACITY);
    assign pos_neg = r_pos[9];
    assign pos_x   = XW'(r_pos[8:0]);
    assign pos_ok  = !pos_neg && (pos_x < cnt_x);
    assign full    = (cnt_x >= cap_x);
    assign empty   = (cnt_x == '0);
    assign at_x    = pos_neg ? '0 : ((pos_x > cnt_x) ? cnt_x : pos_x);
    assign req_x   = XW'(r_len_req);
    assign req_c   = (req_x > cap_x) ? cap_x : req_x;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_res_value  = '0;
        n_res_found  = '1;
        n_res_status = flce_pkg::ST_OK;
        res_load     = 1'b0;
        scan_start   = 1'b0;
        scan_run     = 1'b0;
        ctl.op       = flce_pkg::OP_HOLD;
        ctl.fmode    = flce_pkg::FL_NONE;
        ctl.a        = '0;
        ctl.b        = '0;
        ctl.word     = r_word;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                res_load = 1'b1;
                n_state  = S_DONE;
                case (r_cmd)
                    flce_pkg::CMD_PUSH: begin
                        if (!full) begin
                            ctl.op  = flce_pkg::OP_PUT;
                            ctl.a   = cnt_x;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_res_status = flce_pkg::ST_FULL;
                        end
                    end
                    flce_pkg::CMD_POP: begin
                        if (!empty) begin
                            n_count = r_count - CW'(1);
                        end else begin
                            n_res_status = flce_pkg::ST_EMPTY;
                        end
                    end
                    flce_pkg::CMD_CLEAR: begin
                        // cells past the length are never seen, resize zeroes on growth
                        n_count = '0;
                    end
                    flce_pkg::CMD_ERASE: begin
                        if (pos_ok) begin
                            ctl.op  = flce_pkg::OP_DOWN;
                            ctl.a   = pos_x;
                            n_count = r_count - CW'(1);
                        end else begin
                            n_res_status = flce_pkg::ST_RANGE;
                        end
                    end
                    flce_pkg::CMD_READ: begin
                        if (pos_ok) begin
                            res_load   = 1'b0;
                            scan_start = 1'b1;
                            n_state    = S_SCAN;
                        end else begin
                            n_res_status = flce_pkg::ST_RANGE;
                        end
                    end
                    flce_pkg::CMD_WRITE: begin
                        if (pos_ok) begin
                            ctl.op = flce_pkg::OP_PUT;
                            ctl.a  = pos_x;
                        end else begin
                            n_res_status = flce_pkg::ST_RANGE;
                        end
                    end
                    flce_pkg::CMD_FIND: begin
                        res_load   = 1'b0;
                        scan_start = 1'b1;
                        n_state    = S_SCAN;
                    end
                    flce_pkg::CMD_INSERT: begin
                        if (!full) begin
                            ctl.op  = flce_pkg::OP_UP;
                            ctl.a   = at_x;
                            n_count = r_count + CW'(1);
                        end else begin
                            n_res_status = flce_pkg::ST_FULL;
                        end
                    end
                    flce_pkg::CMD_RESIZE: begin
                        ctl.op  = flce_pkg::OP_ZERO;
                        ctl.a   = cnt_x;
                        ctl.b   = req_c;
                        n_count = CW'(req_c);
                    end
                    default: begin
                        n_count = r_count;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_cmd == flce_pkg::CMD_READ) begin
                    ctl.fmode = flce_pkg::FL_SEL;
                    ctl.a     = pos_x;
                end else begin
                    ctl.fmode = flce_pkg::FL_MATCH;
                    ctl.a     = cnt_x;
                end
                if (scan_st.hit) begin
                    res_load = 1'b1;
                    n_state  = S_DONE;
                    if (r_cmd == flce_pkg::CMD_READ) begin
                        n_res_value = scan_value;
                    end else begin
                        n_res_found = scan_st.index[8:0];
                    end
                end else if (scan_st.last) begin
                    res_load     = 1'b1;
                    n_state      = S_DONE;
                    n_res_status = flce_pkg::ST_NOTFOUND;
                end else begin
                    scan_run = 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd     <= i_cmd;
            r_pos     <= i_position;
            r_word    <= i_word;
            r_len_req <= i_new_length;
        end
        if (res_load) begin
            r_res_value  <= n_res_value;
            r_res_found  <= n_res_found;
            r_res_status <= n_res_status;
        end
        if (r_state == S_DONE && out_free) begin
            r_out_value  <= r_res_value;
            r_out_found  <= r_res_found;
            r_out_length <= 9'(r_count);
            r_out_status <= r_res_status;
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [31:0] left_w, right_w;
        if (k == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_mid_l
            assign left_w = entries[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = entries[k+1];
        end
        flce_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (ctl),
            .i_left  (left_w),
            .i_right (right_w),
            .o_entry (entries[k]),
            .o_flag  (flags[k])
        );
    end

    flce_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (scan_start),
        .i_run     (scan_run),
        .i_flags   (flags),
        .i_entries (entries),
        .o_st      (scan_st),
        .o_value   (scan_value)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_found_index = r_out_found;
    assign o_length      = r_out_length;
    assign o_status      = r_out_status;

endmodule
`default_nettype wire

### hdl/flce_cell.sv
// one list entry cell: shifts with its neighbors and flags a match or a select
`default_nettype none
module flce_cell #(
    parameter int unsigned INDEX = 0
) (
    input  wire logic                          i_clk,
    input  wire flce_pkg::t_cell_ctl           i_ctl,
    input  wire logic [flce_pkg::WORD_W-1:0]   i_left,
    input  wire logic [flce_pkg::WORD_W-1:0]   i_right,
    output logic      [flce_pkg::WORD_W-1:0]   o_entry,
    output logic                               o_flag
);

    localparam logic [flce_pkg::IDX_W-1:0] IDX = flce_pkg::IDX_W'(INDEX);

    logic [flce_pkg::WORD_W-1:0] r_entry;
    logic [flce_pkg::WORD_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        case (i_ctl.op)
            flce_pkg::OP_PUT: begin
                if (IDX == i_ctl.a) begin
                    n_entry = i_ctl.word;
                end
            end
            flce_pkg::OP_DOWN: begin
                if (IDX >= i_ctl.a) begin
                    n_entry = i_right;
                end
            end
            flce_pkg::OP_UP: begin
                if (IDX > i_ctl.a) begin
                    n_entry = i_left;
                end else if (IDX == i_ctl.a) begin
                    n_entry = i_ctl.word;
                end
            end
            flce_pkg::OP_ZERO: begin
                if (IDX >= i_ctl.a && IDX < i_ctl.b) begin
                    n_entry = '0;
                end
            end
            default: begin
                n_entry = r_entry;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_comb begin
        case (i_ctl.fmode)
            flce_pkg::FL_MATCH: o_flag = (r_entry == i_ctl.word) && (IDX < i_ctl.a);
            flce_pkg::FL_SEL:   o_flag = (IDX == i_ctl.a);
            default:            o_flag = 1'b0;
        endcase
    end

    assign o_entry = r_entry;

endmodule
`default_nettype wire

### hdl/flce_scan.sv
// group scan: walks the cell flags sixteen at a time and picks the first one set
`default_nettype none
module flce_scan #(
    parameter int unsigned CAPACITY = flce_pkg::CAP_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_start,
    input  wire logic                                         i_run,
    input  wire logic [CAPACITY-1:0]                          i_flags,
    input  wire logic [CAPACITY-1:0][flce_pkg::WORD_W-1:0]    i_entries,
    output flce_pkg::t_scan_st                                o_st,
    output logic      [flce_pkg::WORD_W-1:0]                  o_value
);

    localparam int unsigned G    = flce_pkg::GROUP_W;
    localparam int unsigned GB   = $clog2(G);
    localparam int unsigned NG0  = (CAPACITY + G - 1) / G;
    localparam int unsigned NG   = (NG0 < 2) ? 2 : NG0;
    localparam int unsigned GCW  = $clog2(NG);

    logic [NG-1:0][G-1:0]                        flag_grp;
    logic [NG-1:0][G-1:0][flce_pkg::WORD_W-1:0]  val_grp;
    logic [GCW-1:0]                              r_grp;
    logic [GB-1:0]                               pe;
    logic [G-1:0]                                sel;

    for (genvar g = 0; g < NG; g++) begin : g_grp
        for (genvar j = 0; j < G; j++) begin : g_lane
            if (g * G + j < CAPACITY) begin : g_real
                assign flag_grp[g][j] = i_flags[g*G+j];
                assign val_grp[g][j]  = i_entries[g*G+j];
            end else begin : g_pad
                assign flag_grp[g][j] = 1'b0;
                assign val_grp[g][j]  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else if (i_start) begin
            r_grp <= '0;
        end else if (i_run) begin
            r_grp <= r_grp + GCW'(1);
        end
    end

    // lowest set lane wins
    always_comb begin
        sel = flag_grp[r_grp];
        pe  = '0;
        for (int j = G - 1; j >= 0; j--) begin
            if (sel[j]) begin
                pe = GB'(j);
            end
        end
    end

    assign o_st.hit   = |sel;
    assign o_st.last  = (r_grp == GCW'(NG - 1));
    assign o_st.index = flce_pkg::IDX_W'({r_grp, pe});
    assign o_value    = val_grp[r_grp][pe];

endmodule
`default_nettype wire

### hdl/flce_checker.sv
// port-level checks on the list engine result channel, bound to the top level
`default_nettype none
module flce_checker #(
    parameter int unsigned CAPACITY = flce_pkg::CAP_DEF
) (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic signed [31:0] o_read_value,
    input wire logic signed [8:0]  o_found_index,
    input wire logic [8:0]         o_length,
    input wire logic [2:0]         o_status
);

    localparam bit SMALL = (CAPACITY <= 511);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_value)
            && $stable(o_found_index) && $stable(o_length) && $stable(o_status))
        else $error("result beat changed while stalled");

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SMALL |-> o_length <= 9'(CAPACITY))
        else $error("length above capacity");

    a_found_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && SMALL && (o_found_index != 9'h1FF) |->
            (o_found_index < o_length) && (o_status == flce_pkg::ST_OK))
        else $error("found index outside the list");

    a_notfound_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == flce_pkg::ST_NOTFOUND) |-> o_found_index == 9'h1FF)
        else $error("not-found beat carries an index");

    a_read_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_value != 32'sd0) |->
            (o_status == flce_pkg::ST_OK) && (o_found_index == 9'h1FF))
        else $error("read data on a failed or non-read beat");

endmodule

bind fixed_capacity_list_engine_core flce_checker #(
    .CAPACITY (CAPACITY)
) u_flce_checker (.*);
`default_nettype wire
